FILE: src/frs2d_pkg.sv
// ----------------------------------------------------------------------------
// frs2d_pkg: shared types and codes of the 2-D Fenwick rectangle-sum block
// Holds the payload structs, the microcode control fields that pass from the
// sequencer to the datapath, and the status flags that pass back.
// ----------------------------------------------------------------------------
package frs2d_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 7;
    localparam int PCW    = 5;

    localparam logic [CFG_W-1:0] COUNT_RST = 7'd64;

    // Configuration register indexes
    localparam logic CFG_ROW_COUNT = 1'b0;
    localparam logic CFG_COL_COUNT = 1'b1;

    // Item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Tree index register operations (row and column alike)
    localparam logic [1:0] IX_HOLD = 2'd0;
    localparam logic [1:0] IX_LOAD = 2'd1;
    localparam logic [1:0] IX_UP   = 2'd2;
    localparam logic [1:0] IX_DOWN = 2'd3;

    // Memory operations
    localparam logic [2:0] M_NONE    = 3'd0;
    localparam logic [2:0] M_CLEAR   = 3'd1;
    localparam logic [2:0] M_RD_CELL = 3'd2;
    localparam logic [2:0] M_WR_CELL = 3'd3;
    localparam logic [2:0] M_RD_TREE = 3'd4;
    localparam logic [2:0] M_WR_TREE = 3'd5;

    // Datapath register operations
    localparam logic [2:0] D_NONE  = 3'd0;
    localparam logic [2:0] D_INIT  = 3'd1;
    localparam logic [2:0] D_DELTA = 3'd2;
    localparam logic [2:0] D_Q_INC = 3'd3;
    localparam logic [2:0] D_EMIT  = 3'd4;

    typedef struct packed {
        logic        opcode;
        logic [5:0]  row_a;
        logic [5:0]  col_a;
        logic [5:0]  row_b;
        logic [5:0]  col_b;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] sum;
        logic        status;
    } out_item_t;

    typedef struct packed {
        logic       take;
        logic [1:0] i_op;
        logic [1:0] j_op;
        logic [2:0] mem_op;
        logic [2:0] dp_op;
    } ctrl_t;

    typedef struct packed {
        logic start;
        logic flag;
        logic query;
        logic clr_more;
        logic i_over;
        logic j_over;
        logic i_zero;
        logic j_nz;
        logic q_last;
        logic out_free;
    } dp_flags_t;

endpackage

FILE: src/frs2d_ram.sv
// ----------------------------------------------------------------------------
// frs2d_ram: single-port word memory
// One access per cycle, read or write, with registered read data.
// ----------------------------------------------------------------------------
module frs2d_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               addr,
    input  logic [frs2d_pkg::DATA_W-1:0] wdata,
    output logic [frs2d_pkg::DATA_W-1:0] rdata
);

    logic [frs2d_pkg::DATA_W-1:0] mem_reg [DEPTH];
    logic [frs2d_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/frs2d_dp.sv
// ----------------------------------------------------------------------------
// frs2d_dp: datapath of the 2-D Fenwick rectangle-sum block
// Item capture, tree index registers, cell and tree memories, delta and
// accumulator, result register. Driven one control word per cycle.
// ----------------------------------------------------------------------------
module frs2d_dp #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  frs2d_pkg::ctrl_t                    ctrl,
    output frs2d_pkg::dp_flags_t                flags,
    input  logic [frs2d_pkg::CFG_W-1:0]         row_count,
    input  logic [frs2d_pkg::CFG_W-1:0]         col_count,
    input  logic                                in_valid,
    input  frs2d_pkg::in_item_t                 in_data,
    input  logic                                out_ready,
    output logic                                out_valid,
    output frs2d_pkg::out_item_t                out_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = $clog2(2 * MAX_ROWS + 1);
    localparam int JW    = $clog2(2 * MAX_COLS + 1);

    frs2d_pkg::in_item_t  item_reg;
    frs2d_pkg::out_item_t out_reg;
    logic                 out_valid_reg;

    logic [IW-1:0] i_reg, i_next, i_low, i_load, row0;
    logic [JW-1:0] j_reg, j_next, j_low, j_load, col0;
    logic [1:0]    q_reg;
    logic [31:0]   acc_reg, delta_reg;
    logic          pend_reg, pend_neg_reg;
    logic [AW-1:0] clr_reg;

    logic [frs2d_pkg::CFG_W-1:0] rows_act, cols_act;
    logic          is_query, flag, clearing;
    logic [AW-1:0] cell_addr, tree_addr, cell_ram_addr, tree_ram_addr;
    logic          cell_we, tree_we;
    logic [31:0]   cell_wdata, tree_wdata, cell_rdata, tree_rdata;

    // Active grid size saturates at the built grid size.
    assign rows_act = (row_count > MAX_ROWS) ? frs2d_pkg::CFG_W'(MAX_ROWS) : row_count;
    assign cols_act = (col_count > MAX_COLS) ? frs2d_pkg::CFG_W'(MAX_COLS) : col_count;

    assign is_query = (item_reg.opcode == frs2d_pkg::OP_QUERY);

    always_comb
    begin
        if (is_query)
        begin
            flag = ({1'b0, item_reg.row_b} >= rows_act)
                || ({1'b0, item_reg.col_b} >= cols_act)
                || (item_reg.row_a > item_reg.row_b)
                || (item_reg.col_a > item_reg.col_b);
        end
        else
        begin
            flag = ({1'b0, item_reg.row_a} >= rows_act)
                || ({1'b0, item_reg.col_a} >= cols_act);
        end
    end

    // Start of a low-bit chain: the cell itself for a write, and for a query
    // the prefix bounds picked by the quadrant counter.
    always_comb
    begin
        if (is_query)
        begin
            i_load = q_reg[1] ? IW'(item_reg.row_a) : IW'({1'b0, item_reg.row_b} + 7'd1);
            j_load = q_reg[0] ? JW'(item_reg.col_a) : JW'({1'b0, item_reg.col_b} + 7'd1);
        end
        else
        begin
            i_load = IW'({1'b0, item_reg.row_a} + 7'd1);
            j_load = JW'({1'b0, item_reg.col_a} + 7'd1);
        end
    end

    assign i_low = i_reg & (~i_reg + 1'b1);
    assign j_low = j_reg & (~j_reg + 1'b1);

    always_comb
    begin
        unique case (ctrl.i_op)
            frs2d_pkg::IX_LOAD: i_next = i_load;
            frs2d_pkg::IX_UP:   i_next = i_reg + i_low;
            frs2d_pkg::IX_DOWN: i_next = i_reg - i_low;
            default:            i_next = i_reg;
        endcase
        unique case (ctrl.j_op)
            frs2d_pkg::IX_LOAD: j_next = j_load;
            frs2d_pkg::IX_UP:   j_next = j_reg + j_low;
            frs2d_pkg::IX_DOWN: j_next = j_reg - j_low;
            default:            j_next = j_reg;
        endcase
    end

    assign row0      = i_reg - 1'b1;
    assign col0      = j_reg - 1'b1;
    assign tree_addr = AW'(AW'(row0) * AW'(MAX_COLS) + AW'(col0));
    assign cell_addr = AW'(AW'(item_reg.row_a) * AW'(MAX_COLS) + AW'(item_reg.col_a));

    assign clearing      = (ctrl.mem_op == frs2d_pkg::M_CLEAR);
    assign cell_ram_addr = clearing ? clr_reg : cell_addr;
    assign tree_ram_addr = clearing ? clr_reg : tree_addr;
    assign cell_we       = clearing || (ctrl.mem_op == frs2d_pkg::M_WR_CELL);
    assign tree_we       = clearing || (ctrl.mem_op == frs2d_pkg::M_WR_TREE);
    assign cell_wdata    = clearing ? '0 : $unsigned(item_reg.value);
    assign tree_wdata    = clearing ? '0 : tree_rdata + delta_reg;

    frs2d_ram #(.DEPTH(DEPTH), .AW(AW)) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .addr  (cell_ram_addr),
        .wdata (cell_wdata),
        .rdata (cell_rdata)
    );

    frs2d_ram #(.DEPTH(DEPTH), .AW(AW)) u_tree_ram (
        .clk   (clk),
        .we    (tree_we),
        .addr  (tree_ram_addr),
        .wdata (tree_wdata),
        .rdata (tree_rdata)
    );

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && ctrl.take)
        begin
            item_reg <= in_data;
        end
        i_reg <= i_next;
        j_reg <= j_next;
        if (ctrl.dp_op == frs2d_pkg::D_DELTA)
        begin
            delta_reg <= $unsigned(item_reg.value) - cell_rdata;
        end
        if (ctrl.dp_op == frs2d_pkg::D_EMIT)
        begin
            out_reg.sum    <= $signed(acc_reg);
            out_reg.status <= flag;
        end
    end

    // A query tree read lands in the following cycle and is folded into the
    // accumulator with the sign of the quadrant that issued it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg         <= '0;
            acc_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_neg_reg  <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg     <= (ctrl.mem_op == frs2d_pkg::M_RD_TREE) && is_query;
            pend_neg_reg <= q_reg[0] ^ q_reg[1];
            if (clearing)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (ctrl.dp_op == frs2d_pkg::D_INIT)
            begin
                acc_reg <= '0;
                q_reg   <= '0;
            end
            else
            begin
                if (pend_reg)
                begin
                    acc_reg <= pend_neg_reg ? acc_reg - tree_rdata : acc_reg + tree_rdata;
                end
                if (ctrl.dp_op == frs2d_pkg::D_Q_INC)
                begin
                    q_reg <= q_reg + 1'b1;
                end
            end
            if (ctrl.dp_op == frs2d_pkg::D_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign flags.start    = in_valid;
    assign flags.flag     = flag;
    assign flags.query    = is_query;
    assign flags.clr_more = (clr_reg != AW'(DEPTH - 1));
    assign flags.i_over   = (i_reg > IW'(MAX_ROWS));
    assign flags.j_over   = (j_reg > JW'(MAX_COLS));
    assign flags.i_zero   = (i_reg == '0);
    assign flags.j_nz     = (j_reg != '0);
    assign flags.q_last   = (q_reg == 2'd3);
    assign flags.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: src/frs2d_seq.sv
// ----------------------------------------------------------------------------
// frs2d_seq: microcode sequencer
// A step counter walks a read-only program. Each control word carries a jump
// condition, a target and the datapath controls for that step.
// ----------------------------------------------------------------------------
module frs2d_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  frs2d_pkg::dp_flags_t  flags,
    output frs2d_pkg::ctrl_t      ctrl
);

    localparam int PCW = frs2d_pkg::PCW;

    // Jump conditions
    localparam logic [3:0] C_NONE     = 4'd0;
    localparam logic [3:0] C_ALWAYS   = 4'd1;
    localparam logic [3:0] C_NO_START = 4'd2;
    localparam logic [3:0] C_FLAG     = 4'd3;
    localparam logic [3:0] C_QUERY    = 4'd4;
    localparam logic [3:0] C_CLR_MORE = 4'd5;
    localparam logic [3:0] C_I_OVER   = 4'd6;
    localparam logic [3:0] C_J_OVER   = 4'd7;
    localparam logic [3:0] C_I_ZERO   = 4'd8;
    localparam logic [3:0] C_J_NZ     = 4'd9;
    localparam logic [3:0] C_Q_LAST   = 4'd10;
    localparam logic [3:0] C_OUT_FREE = 4'd11;

    // Program steps
    localparam logic [PCW-1:0] S_CLEAR      = 5'd0;
    localparam logic [PCW-1:0] S_IDLE       = 5'd1;
    localparam logic [PCW-1:0] S_CHECK      = 5'd2;
    localparam logic [PCW-1:0] S_DISPATCH   = 5'd3;
    localparam logic [PCW-1:0] S_W_RDCELL   = 5'd4;
    localparam logic [PCW-1:0] S_W_DELTA    = 5'd5;
    localparam logic [PCW-1:0] S_W_ROW      = 5'd6;
    localparam logic [PCW-1:0] S_W_COL      = 5'd7;
    localparam logic [PCW-1:0] S_W_RDTREE   = 5'd8;
    localparam logic [PCW-1:0] S_W_WRTREE   = 5'd9;
    localparam logic [PCW-1:0] S_W_NEXTROW  = 5'd10;
    localparam logic [PCW-1:0] S_Q_START    = 5'd11;
    localparam logic [PCW-1:0] S_Q_ROW      = 5'd12;
    localparam logic [PCW-1:0] S_Q_COL      = 5'd13;
    localparam logic [PCW-1:0] S_Q_NEXTROW  = 5'd14;
    localparam logic [PCW-1:0] S_Q_NEXT     = 5'd15;
    localparam logic [PCW-1:0] S_Q_LOOP     = 5'd16;
    localparam logic [PCW-1:0] S_DONE       = 5'd17;
    localparam logic [PCW-1:0] S_WAIT       = 5'd18;

    // A guarded word applies its controls only when its jump is taken.
    typedef struct packed {
        logic [3:0]       cond;
        logic [PCW-1:0]   target;
        logic             guard;
        frs2d_pkg::ctrl_t ctrl;
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [PCW-1:0] step);
        ucode_t w;
        w = '0;
        unique case (step)
            S_CLEAR:
            begin
                w.cond = C_CLR_MORE; w.target = S_CLEAR;
                w.ctrl.mem_op = frs2d_pkg::M_CLEAR;
            end
            S_IDLE:
            begin
                w.cond = C_NO_START; w.target = S_IDLE;
                w.ctrl.take = 1'b1;
            end
            S_CHECK:
            begin
                w.cond = C_FLAG; w.target = S_DONE;
                w.ctrl.dp_op = frs2d_pkg::D_INIT;
            end
            S_DISPATCH:
            begin
                w.cond = C_QUERY; w.target = S_Q_START;
            end
            S_W_RDCELL:
            begin
                w.ctrl.mem_op = frs2d_pkg::M_RD_CELL;
                w.ctrl.i_op   = frs2d_pkg::IX_LOAD;
            end
            S_W_DELTA:
            begin
                w.ctrl.mem_op = frs2d_pkg::M_WR_CELL;
                w.ctrl.dp_op  = frs2d_pkg::D_DELTA;
            end
            S_W_ROW:
            begin
                w.cond = C_I_OVER; w.target = S_DONE;
                w.ctrl.j_op = frs2d_pkg::IX_LOAD;
            end
            S_W_COL:
            begin
                w.cond = C_J_OVER; w.target = S_W_NEXTROW;
            end
            S_W_RDTREE:
            begin
                w.ctrl.mem_op = frs2d_pkg::M_RD_TREE;
            end
            S_W_WRTREE:
            begin
                w.cond = C_ALWAYS; w.target = S_W_COL;
                w.ctrl.mem_op = frs2d_pkg::M_WR_TREE;
                w.ctrl.j_op   = frs2d_pkg::IX_UP;
            end
            S_W_NEXTROW:
            begin
                w.cond = C_ALWAYS; w.target = S_W_ROW;
                w.ctrl.i_op = frs2d_pkg::IX_UP;
            end
            S_Q_START:
            begin
                w.ctrl.i_op = frs2d_pkg::IX_LOAD;
            end
            S_Q_ROW:
            begin
                w.cond = C_I_ZERO; w.target = S_Q_NEXT;
                w.ctrl.j_op = frs2d_pkg::IX_LOAD;
            end
            S_Q_COL:
            begin
                w.cond = C_J_NZ; w.target = S_Q_COL; w.guard = 1'b1;
                w.ctrl.mem_op = frs2d_pkg::M_RD_TREE;
                w.ctrl.j_op   = frs2d_pkg::IX_DOWN;
            end
            S_Q_NEXTROW:
            begin
                w.cond = C_ALWAYS; w.target = S_Q_ROW;
                w.ctrl.i_op = frs2d_pkg::IX_DOWN;
            end
            S_Q_NEXT:
            begin
                w.cond = C_Q_LAST; w.target = S_DONE;
                w.ctrl.dp_op = frs2d_pkg::D_Q_INC;
            end
            S_Q_LOOP:
            begin
                w.cond = C_ALWAYS; w.target = S_Q_START;
            end
            S_DONE:
            begin
                w.cond = C_OUT_FREE; w.target = S_IDLE; w.guard = 1'b1;
                w.ctrl.dp_op = frs2d_pkg::D_EMIT;
            end
            S_WAIT:
            begin
                w.cond = C_ALWAYS; w.target = S_DONE;
            end
            default:
            begin
                w.cond = C_ALWAYS; w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

    logic [PCW-1:0] pc_reg, pc_next;
    ucode_t         cw;
    logic           taken;

    always_comb
    begin
        cw = ucode_rom(pc_reg);
        unique case (cw.cond)
            C_ALWAYS:   taken = 1'b1;
            C_NO_START: taken = !flags.start;
            C_FLAG:     taken = flags.flag;
            C_QUERY:    taken = flags.query;
            C_CLR_MORE: taken = flags.clr_more;
            C_I_OVER:   taken = flags.i_over;
            C_J_OVER:   taken = flags.j_over;
            C_I_ZERO:   taken = flags.i_zero;
            C_J_NZ:     taken = flags.j_nz;
            C_Q_LAST:   taken = flags.q_last;
            C_OUT_FREE: taken = flags.out_free;
            default:    taken = 1'b0;
        endcase
        pc_next = taken ? cw.target : pc_reg + 1'b1;
        ctrl    = (cw.guard && !taken) ? '0 : cw.ctrl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_CLEAR;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

FILE: src/fenwick_rect_sum_2d.sv
// ----------------------------------------------------------------------------
// fenwick_rect_sum_2d: rectangle sums over a grid held in a 2-D Fenwick tree
// Top level: configuration registers, microcode sequencer and datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on in_valid/in_ready/in_data. A write item sets one
//   cell; a query item asks for the inclusive rectangle sum. Every item gives
//   exactly one result transaction on out_valid/out_ready/out_data, with
//   status set and a zero sum when an index is out of range or reversed.
//   row_count and col_count are written through cfg_we/cfg_index/cfg_data
//   while no item is in flight.
//   One item is worked at a time; the tree memory's single port, one access
//   per cycle, sets the pace. A write walks the row and column update
//   chains, each up to 7 entries long at a 64 x 64 grid. A query walks,
//   for each of its four prefixes, the row and column chains down from the
//   prefix bounds, as long as the bounds have set bits.
//   After reset both memories are cleared, one entry per cycle through all
//   MAX_ROWS*MAX_COLS entries, before in_ready first rises.
//   A finished result sits in the output register while the receiver
//   stalls; the block still takes and works the next item, but holds it at
//   its last step, taking nothing further, until the result is taken.
// ----------------------------------------------------------------------------
module fenwick_rect_sum_2d #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  frs2d_pkg::in_item_t           in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output frs2d_pkg::out_item_t          out_data,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [frs2d_pkg::CFG_W-1:0]   cfg_data
);

    logic [frs2d_pkg::CFG_W-1:0] row_count_reg, col_count_reg;
    frs2d_pkg::ctrl_t            ctrl;
    frs2d_pkg::dp_flags_t        flags;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= frs2d_pkg::COUNT_RST;
            col_count_reg <= frs2d_pkg::COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                frs2d_pkg::CFG_ROW_COUNT: row_count_reg <= cfg_data;
                frs2d_pkg::CFG_COL_COUNT: col_count_reg <= cfg_data;
            endcase
        end
    end

    frs2d_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    frs2d_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .flags     (flags),
        .row_count (row_count_reg),
        .col_count (col_count_reg),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign in_ready = ctrl.take;

endmodule

FILE: tb/tb_fenwick_rect_sum_2d.sv
// ----------------------------------------------------------------------------
// tb_fenwick_rect_sum_2d: testbench of the 2-D Fenwick rectangle-sum block
// Drives cell writes and rectangle queries through the valid/ready input,
// predicts every result with a Fenwick tree of its own and checks each result
// transaction in order. Grid sizes are changed between phases while the block
// is idle, and the receiver stalls at random and once for a long stretch.
// ----------------------------------------------------------------------------
module tb_fenwick_rect_sum_2d;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 64;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    frs2d_pkg::in_item_t  in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    frs2d_pkg::out_item_t out_data;
    logic                 cfg_we = 1'b0;
    logic                 cfg_index = frs2d_pkg::CFG_ROW_COUNT;
    logic [frs2d_pkg::CFG_W-1:0] cfg_data = '0;

    // Predicted grid: Fenwick tree, cell copies and the two size registers.
    logic [31:0]      fen_tree  [0:GRID_ROWS*GRID_COLS-1];
    logic [31:0]      cell_copy [0:GRID_ROWS*GRID_COLS-1];
    logic [frs2d_pkg::CFG_W-1:0] row_limit = frs2d_pkg::COUNT_RST;
    logic [frs2d_pkg::CFG_W-1:0] col_limit = frs2d_pkg::COUNT_RST;

    frs2d_pkg::out_item_t pending_results[$];
    int        errors = 0;
    bit        quiet = 1'b0;        // no random gaps on either side while set
    int        hold_request = 0;    // long receiver hold-off, in cycles

    fenwick_rect_sum_2d #(
        .MAX_ROWS (GRID_ROWS),
        .MAX_COLS (GRID_COLS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        #30_000_000;
        $display("FAIL fenwick_rect_sum_2d");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Grid predictor
    // ------------------------------------------------------------------------
    function automatic int unsigned low_bit(int unsigned x);
        return x & (~x + 1);
    endfunction

    function automatic int unsigned active_rows();
        return (row_limit > GRID_ROWS) ? GRID_ROWS : row_limit;
    endfunction

    function automatic int unsigned active_cols();
        return (col_limit > GRID_COLS) ? GRID_COLS : col_limit;
    endfunction

    // Sum over the first nr rows and nc columns.
    function automatic logic [31:0] prefix_total(int unsigned nr, int unsigned nc);
        logic [31:0] acc;
        int unsigned i;
        int unsigned j;
        acc = '0;
        for (i = nr; i > 0; i -= low_bit(i))
        begin
            for (j = nc; j > 0; j -= low_bit(j))
            begin
                acc += fen_tree[(i - 1) * GRID_COLS + (j - 1)];
            end
        end
        return acc;
    endfunction

    function automatic void spread_delta(int unsigned r, int unsigned c, logic [31:0] delta);
        int unsigned i;
        int unsigned j;
        for (i = r + 1; i <= GRID_ROWS; i += low_bit(i))
        begin
            for (j = c + 1; j <= GRID_COLS; j += low_bit(j))
            begin
                fen_tree[(i - 1) * GRID_COLS + (j - 1)] += delta;
            end
        end
    endfunction

    function automatic frs2d_pkg::out_item_t apply_item(frs2d_pkg::in_item_t item);
        frs2d_pkg::out_item_t res;
        int unsigned rows;
        int unsigned cols;
        int unsigned ra;
        int unsigned ca;
        int unsigned rb;
        int unsigned cb;
        int unsigned slot;
        rows = active_rows();
        cols = active_cols();
        ra = item.row_a;
        ca = item.col_a;
        rb = item.row_b;
        cb = item.col_b;
        res.sum = '0;
        res.status = 1'b0;
        if (item.opcode == frs2d_pkg::OP_WRITE)
        begin
            if (ra >= rows || ca >= cols)
            begin
                res.status = 1'b1;
            end
            else
            begin
                slot = ra * GRID_COLS + ca;
                spread_delta(ra, ca, item.value - cell_copy[slot]);
                cell_copy[slot] = item.value;
            end
        end
        else
        begin
            if (rb >= rows || cb >= cols || ra > rb || ca > cb)
            begin
                res.status = 1'b1;
            end
            else
            begin
                res.sum = prefix_total(rb + 1, cb + 1) - prefix_total(rb + 1, ca)
                        - prefix_total(ra, cb + 1) + prefix_total(ra, ca);
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (quiet)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic frs2d_pkg::in_item_t make_item(logic op, int unsigned ra,
                                                      int unsigned ca, int unsigned rb,
                                                      int unsigned cb, logic [31:0] val);
        frs2d_pkg::in_item_t item;
        item.opcode = op;
        item.row_a = 6'(ra);
        item.col_a = 6'(ca);
        item.row_b = 6'(rb);
        item.col_b = 6'(cb);
        item.value = val;
        return item;
    endfunction

    // Mostly well-formed items inside the active grid; the rest is raw noise.
    function automatic frs2d_pkg::in_item_t random_item();
        frs2d_pkg::in_item_t item;
        int unsigned rows;
        int unsigned cols;
        int unsigned r0;
        int unsigned r1;
        int unsigned c0;
        int unsigned c1;
        rows = active_rows();
        cols = active_cols();
        item.opcode = 1'($urandom_range(0, 1));
        item.row_a = 6'($urandom);
        item.col_a = 6'($urandom);
        item.row_b = 6'($urandom);
        item.col_b = 6'($urandom);
        item.value = $urandom;
        if ($urandom_range(0, 99) < 15)
        begin
            case ($urandom_range(0, 3))
                0: item.value = 32'h7FFF_FFFF;
                1: item.value = 32'h8000_0000;
                2: item.value = 32'h0000_0000;
                default: item.value = 32'hFFFF_FFFF;
            endcase
        end
        if ($urandom_range(0, 9) != 0 && rows > 0 && cols > 0)
        begin
            r0 = $urandom_range(0, rows - 1);
            r1 = $urandom_range(0, rows - 1);
            c0 = $urandom_range(0, cols - 1);
            c1 = $urandom_range(0, cols - 1);
            if ($urandom_range(0, 4) == 0)
            begin
                r1 = r0;
            end
            if ($urandom_range(0, 4) == 0)
            begin
                c1 = c0;
            end
            if (item.opcode == frs2d_pkg::OP_WRITE)
            begin
                item.row_a = 6'(r0);
                item.col_a = 6'(c0);
            end
            else
            begin
                item.row_a = 6'((r0 < r1) ? r0 : r1);
                item.row_b = 6'((r0 < r1) ? r1 : r0);
                item.col_a = 6'((c0 < c1) ? c0 : c1);
                item.col_b = 6'((c0 < c1) ? c1 : c0);
            end
        end
        return item;
    endfunction

    // Offers one item and returns in the time step of its acceptance.
    // in_valid is left high so that a back-to-back item needs no toggle.
    task automatic send_item(input frs2d_pkg::in_item_t item);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(apply_item(item));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input int unsigned data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= frs2d_pkg::CFG_W'(data);
        if (idx == frs2d_pkg::CFG_ROW_COUNT)
        begin
            row_limit = frs2d_pkg::CFG_W'(data);
        end
        else
        begin
            col_limit = frs2d_pkg::CFG_W'(data);
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_grid(input int unsigned rows, input int unsigned cols);
        wait_idle();
        write_reg(frs2d_pkg::CFG_ROW_COUNT, rows);
        write_reg(frs2d_pkg::CFG_COL_COUNT, cols);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_full_grid_extremes();
        send_item(make_item(frs2d_pkg::OP_WRITE, 0, 0, 0, 0, 32'h7FFF_FFFF));
        send_item(make_item(frs2d_pkg::OP_WRITE, 63, 63, 0, 0, 32'h8000_0000));
        send_item(make_item(frs2d_pkg::OP_WRITE, 31, 32, 63, 63, 32'd123));
        send_item(make_item(frs2d_pkg::OP_QUERY, 0, 0, 63, 63, 32'hFFFF_FFFF));
        send_item(make_item(frs2d_pkg::OP_QUERY, 63, 63, 63, 63, 32'd0));
        // Overwriting a cell adds only the difference to the tree.
        send_item(make_item(frs2d_pkg::OP_WRITE, 0, 0, 63, 63, 32'hFFFF_FFFF));
        send_item(make_item(frs2d_pkg::OP_QUERY, 0, 0, 0, 0, 32'd0));
        send_item(make_item(frs2d_pkg::OP_QUERY, 0, 0, 31, 63, 32'd0));
        send_item(make_item(frs2d_pkg::OP_QUERY, 10, 0, 5, 63, 32'd0));
        send_item(make_item(frs2d_pkg::OP_QUERY, 0, 40, 63, 39, 32'd0));
        send_item(make_item(frs2d_pkg::OP_QUERY, 31, 32, 31, 32, 32'd0));
    endtask

    task automatic test_single_cell_grid();
        set_grid(1, 1);
        send_item(make_item(frs2d_pkg::OP_WRITE, 0, 0, 0, 0, 32'd5));
        send_item(make_item(frs2d_pkg::OP_WRITE, 1, 0, 0, 0, 32'd9));
        send_item(make_item(frs2d_pkg::OP_WRITE, 0, 1, 0, 0, 32'd9));
        send_item(make_item(frs2d_pkg::OP_QUERY, 0, 0, 0, 0, 32'd0));
        send_item(make_item(frs2d_pkg::OP_QUERY, 0, 0, 0, 1, 32'd0));
    endtask

    task automatic test_empty_grid();
        set_grid(0, 64);
        send_item(make_item(frs2d_pkg::OP_WRITE, 0, 0, 0, 0, 32'd7));
        send_item(make_item(frs2d_pkg::OP_QUERY, 0, 0, 0, 0, 32'd0));
        set_grid(64, 0);
        send_item(make_item(frs2d_pkg::OP_QUERY, 0, 0, 0, 0, 32'd0));
    endtask

    task automatic test_oversized_counts();
        set_grid(127, 100);
        send_item(make_item(frs2d_pkg::OP_WRITE, 63, 63, 0, 0, 32'd42));
        send_item(make_item(frs2d_pkg::OP_QUERY, 0, 0, 63, 63, 32'd0));
    endtask

    // Cells outside a shrunken grid keep their values for when it grows back.
    task automatic test_resize_keeps_cells();
        set_grid(8, 8);
        send_item(make_item(frs2d_pkg::OP_QUERY, 0, 0, 7, 7, 32'd0));
        send_item(make_item(frs2d_pkg::OP_QUERY, 0, 0, 63, 63, 32'd0));
        send_item(make_item(frs2d_pkg::OP_WRITE, 8, 0, 0, 0, 32'd1));
        set_grid(64, 64);
        send_item(make_item(frs2d_pkg::OP_QUERY, 0, 0, 63, 63, 32'd0));
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        quiet = 1'b1;
        hold_request = 400;
        repeat (8) send_item(random_item());
        quiet = 1'b0;
    endtask

    task automatic test_random_phases();
        int unsigned rows;
        int unsigned cols;
        for (int phase = 0; phase < 12; phase++)
        begin
            case ($urandom_range(0, 9))
                0: begin rows = 64; cols = 64; end
                1: begin rows = 1; cols = $urandom_range(1, 64); end
                2: begin rows = $urandom_range(1, 8); cols = $urandom_range(1, 8); end
                3: begin rows = $urandom_range(65, 127); cols = $urandom_range(1, 127); end
                default: begin rows = $urandom_range(1, 64); cols = $urandom_range(1, 64); end
            endcase
            set_grid(rows, cols);
            quiet = (phase == 5);
            repeat (100) send_item(random_item());
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver and result check
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                stall_left = pick_gap();
                out_ready <= (stall_left == 0);
                if (stall_left > 0)
                begin
                    stall_left--;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        frs2d_pkg::out_item_t want;
        if (out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected result transaction, sum %0d status %0b",
                         $time, out_data.sum, out_data.status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.sum !== want.sum)
                begin
                    errors++;
                    $display("%0t ns: sum mismatch, expected %0d, actual %0d",
                             $time, want.sum, out_data.sum);
                end
                if (out_data.status !== want.status)
                begin
                    errors++;
                    $display("%0t ns: status mismatch, expected %0b, actual %0b",
                             $time, want.status, out_data.status);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        int waited;
        foreach (fen_tree[k])
        begin
            fen_tree[k] = '0;
            cell_copy[k] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_full_grid_extremes();
        test_single_cell_grid();
        test_empty_grid();
        test_oversized_counts();
        test_resize_keeps_cells();
        test_output_backpressure();
        test_random_phases();

        in_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (300) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            errors++;
            $display("%0t ns: %0d expected results never arrived",
                     $time, pending_results.size());
        end

        if (errors == 0)
        begin
            $display("PASS fenwick_rect_sum_2d");
        end
        else
        begin
            $display("FAIL fenwick_rect_sum_2d");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/frs2d_pkg.sv
src/frs2d_ram.sv
src/frs2d_dp.sv
src/frs2d_seq.sv
src/fenwick_rect_sum_2d.sv
tb/tb_fenwick_rect_sum_2d.sv
